>>> rtl/rhc_pkg.sv
package rhc_pkg;

	// Default sizes
	localparam int COMPONENT_BITS    = 8;
	localparam int HUE_FRACTION_BITS = 6;

	// Port widths
	localparam int IN_W  = 8;
	localparam int HUE_W = 15;
	localparam int SAT_W = 8;
	localparam int VAL_W = 8;

	// Hue geometry in whole degrees; 60 needs SECTOR_BITS bits
	localparam int DEG_SECTOR  = 60;
	localparam int DEG_FULL    = 360;
	localparam int SECTOR_BITS = 6;

	// Which component holds the maximum
	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	// Per-item control that rides along the divider
	typedef struct packed {
		sector_t sector;
		logic    neg;
		logic    undef;
		logic    gray;
	} hue_ctl_t;

endpackage

>>> rtl/rgb_to_hsv_converter.sv
// RGB to HSV pixel converter. Takes one pixel per clock while the output is taken and
// returns one result per pixel in order. Brightness is the largest component, saturation
// is floor(delta*fullscale/max), and hue is in 1/2^HUE_FRACTION_BITS degree (1/64 by
// default, range 0..23039), 0 for gray pixels; black sets hue_undefined with hue and
// saturation 0. Registered front stages find max, min and the dividends, two restoring
// dividers run side by side with one quotient bit per stage, and back stages add the
// sector offset and wrap the hue. Output stalls propagate back stage by stage, so empty
// stages keep filling while a result waits.
module rgb_to_hsv_converter #(
	parameter int COMPONENT_BITS    = rhc_pkg::COMPONENT_BITS,
	parameter int HUE_FRACTION_BITS = rhc_pkg::HUE_FRACTION_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [rhc_pkg::IN_W-1:0]  red,
	input  logic [rhc_pkg::IN_W-1:0]  green,
	input  logic [rhc_pkg::IN_W-1:0]  blue,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [rhc_pkg::HUE_W-1:0] hue,
	output logic [rhc_pkg::SAT_W-1:0] saturation,
	output logic [rhc_pkg::VAL_W-1:0] brightness,
	output logic                      hue_undefined
);

	localparam int CB = COMPONENT_BITS;
	localparam int QH = rhc_pkg::SECTOR_BITS + HUE_FRACTION_BITS;
	localparam int QB = (CB > QH) ? CB : QH;
	localparam int NW = CB + QB;

	logic              f_valid, f_ready;
	logic [NW-1:0]     f_sat_num, f_hue_num;
	logic [CB-1:0]     f_mx, f_delta;
	rhc_pkg::hue_ctl_t f_ctl;

	logic              d_valid, d_ready;
	logic [QB-1:0]     d_quo_sat, d_quo_hue;
	logic [CB-1:0]     d_mx;
	rhc_pkg::hue_ctl_t d_ctl;

	// Extremes, sector and dividends
	rhc_front #(
		.CB (CB),
		.HF (HUE_FRACTION_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.sat_num   (f_sat_num),
		.hue_num   (f_hue_num),
		.mx        (f_mx),
		.delta     (f_delta),
		.ctl       (f_ctl)
	);

	// Saturation and hue quotients
	rhc_div #(
		.CB (CB),
		.QB (QB)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.num_a     (f_sat_num),
		.den_a     (f_mx),
		.num_b     (f_hue_num),
		.den_b     (f_delta),
		.ctl_in    (f_ctl),
		.out_valid (d_valid),
		.out_ready (d_ready),
		.quo_a     (d_quo_sat),
		.quo_b     (d_quo_hue),
		.den_a_out (d_mx),
		.ctl_out   (d_ctl)
	);

	// Offset, wrap and output register
	rhc_back #(
		.CB (CB),
		.HF (HUE_FRACTION_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (d_valid),
		.in_ready      (d_ready),
		.quo_sat       (d_quo_sat),
		.quo_hue       (d_quo_hue),
		.mx            (d_mx),
		.ctl           (d_ctl),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.hue           (hue),
		.saturation    (saturation),
		.brightness    (brightness),
		.hue_undefined (hue_undefined)
	);

`ifndef ASSERT_OFF
	// A black pixel carries no hue and no saturation
	a_black_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hue_undefined |-> hue == '0 && saturation == '0 && brightness == '0)
		else $error("black item with nonzero hue, saturation or brightness");

	// A taking sink lets the whole pipeline advance, so input is open
	a_full_rate: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input blocked while output is being taken");

	// Hold a stalled result unchanged until it is taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hue) && $stable(saturation) &&
			$stable(brightness) && $stable(hue_undefined))
		else $error("stalled item changed or dropped");
`endif

endmodule

>>> rtl/rhc_front.sv
module rhc_front #(
	parameter int CB = rhc_pkg::COMPONENT_BITS,
	parameter int HF = rhc_pkg::HUE_FRACTION_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [rhc_pkg::IN_W-1:0] red,
	input  logic [rhc_pkg::IN_W-1:0] green,
	input  logic [rhc_pkg::IN_W-1:0] blue,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [CB+((CB > rhc_pkg::SECTOR_BITS+HF) ? CB : rhc_pkg::SECTOR_BITS+HF)-1:0] sat_num,
	output logic [CB+((CB > rhc_pkg::SECTOR_BITS+HF) ? CB : rhc_pkg::SECTOR_BITS+HF)-1:0] hue_num,
	output logic [CB-1:0]            mx,
	output logic [CB-1:0]            delta,
	output rhc_pkg::hue_ctl_t        ctl
);

	localparam int QH   = rhc_pkg::SECTOR_BITS + HF;
	localparam int QB   = (CB > QH) ? CB : QH;
	localparam int NW   = CB + QB;
	localparam int Sect = rhc_pkg::DEG_SECTOR * (2 ** HF);

	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	logic [CB-1:0] r_s1, g_s1, b_s1;

	logic [CB-1:0]        mx_c, mn_c;
	rhc_pkg::sector_t     sec_c;
	logic signed [CB:0]   diff_c;

	logic [CB-1:0]        mx_s2, mn_s2;
	rhc_pkg::sector_t     sec_s2;
	logic signed [CB:0]   diff_s2;

	logic [CB-1:0]        delta_c;
	logic signed [CB:0]   absd_c;
	logic [CB-1:0]        mag_c;
	logic [NW-1:0]        sat_num_c, hue_num_c;
	rhc_pkg::hue_ctl_t    ctl_c;

	logic [NW-1:0]        sat_num_s3, hue_num_s3;
	logic [CB-1:0]        mx_s3, delta_s3;
	rhc_pkg::hue_ctl_t    ctl_s3;

	// Advance a stage when it is empty or its successor advances
	assign rdy_s3   = !v_s3 || out_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	// Capture the item, keeping only the component bits
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			r_s1 <= CB'(red);
			g_s1 <= CB'(green);
			b_s1 <= CB'(blue);
		end
	end

	// Find max, min and the sector; red wins ties, then green
	always_comb begin
		mx_c = r_s1;
		mn_c = r_s1;
		if (g_s1 > mx_c) mx_c = g_s1;
		if (b_s1 > mx_c) mx_c = b_s1;
		if (g_s1 < mn_c) mn_c = g_s1;
		if (b_s1 < mn_c) mn_c = b_s1;
		priority if (r_s1 >= g_s1 && r_s1 >= b_s1) begin
			sec_c  = rhc_pkg::SEC_RED;
			diff_c = $signed({1'b0, g_s1}) - $signed({1'b0, b_s1});
		end else if (g_s1 >= b_s1) begin
			sec_c  = rhc_pkg::SEC_GREEN;
			diff_c = $signed({1'b0, b_s1}) - $signed({1'b0, r_s1});
		end else begin
			sec_c  = rhc_pkg::SEC_BLUE;
			diff_c = $signed({1'b0, r_s1}) - $signed({1'b0, g_s1});
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			mx_s2   <= mx_c;
			mn_s2   <= mn_c;
			sec_s2  <= sec_c;
			diff_s2 <= diff_c;
		end
	end

	// Build both dividends: delta * fullscale and sector * |diff|
	always_comb begin
		delta_c       = mx_s2 - mn_s2;
		absd_c        = diff_s2[CB] ? -diff_s2 : diff_s2;
		mag_c         = absd_c[CB-1:0];
		sat_num_c     = NW'({delta_c, {CB{1'b0}}}) - NW'(delta_c);
		hue_num_c     = NW'(Sect) * NW'(mag_c);
		ctl_c.sector  = sec_s2;
		ctl_c.neg     = diff_s2[CB];
		ctl_c.undef   = (mx_s2 == '0);
		ctl_c.gray    = (delta_c == '0);
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			sat_num_s3 <= sat_num_c;
			hue_num_s3 <= hue_num_c;
			mx_s3      <= mx_s2;
			delta_s3   <= delta_c;
			ctl_s3     <= ctl_c;
		end
	end

	assign out_valid = v_s3;
	assign sat_num   = sat_num_s3;
	assign hue_num   = hue_num_s3;
	assign mx        = mx_s3;
	assign delta     = delta_s3;
	assign ctl       = ctl_s3;

endmodule

>>> rtl/rhc_div.sv
module rhc_div #(
	parameter int CB = rhc_pkg::COMPONENT_BITS,
	parameter int QB = rhc_pkg::COMPONENT_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CB+QB-1:0]  num_a,
	input  logic [CB-1:0]     den_a,
	input  logic [CB+QB-1:0]  num_b,
	input  logic [CB-1:0]     den_b,
	input  rhc_pkg::hue_ctl_t ctl_in,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [QB-1:0]     quo_a,
	output logic [QB-1:0]     quo_b,
	output logic [CB-1:0]     den_a_out,
	output rhc_pkg::hue_ctl_t ctl_out
);

	localparam int NW = CB + QB;

	// One quotient bit per stage, most significant first
	logic              v_s   [QB];
	logic              rdy   [QB];
	logic [NW-1:0]     rem_a_s [QB];
	logic [NW-1:0]     rem_b_s [QB];
	logic [CB-1:0]     den_a_s [QB];
	logic [CB-1:0]     den_b_s [QB];
	logic [QB-1:0]     q_a_s   [QB];
	logic [QB-1:0]     q_b_s   [QB];
	rhc_pkg::hue_ctl_t ctl_s   [QB];

	logic [NW-1:0]     pra   [QB];
	logic [NW-1:0]     prb   [QB];
	logic [CB-1:0]     pda   [QB];
	logic [CB-1:0]     pdb   [QB];
	logic [QB-1:0]     pqa   [QB];
	logic [QB-1:0]     pqb   [QB];
	rhc_pkg::hue_ctl_t pctl  [QB];
	logic [NW-1:0]     sha   [QB];
	logic [NW-1:0]     shb   [QB];
	logic              ge_a  [QB];
	logic              ge_b  [QB];

	// Ready ripples back from the output through every stage
	for (genvar k = 0; k < QB; k++) begin : g_rdy
		if (k == QB - 1) begin : g_last
			assign rdy[k] = !v_s[k] || out_ready;
		end else begin : g_mid
			assign rdy[k] = !v_s[k] || rdy[k+1];
		end
	end

	assign in_ready = rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QB; k++) begin
				v_s[k] <= 1'b0;
			end
		end else begin
			for (int k = 0; k < QB; k++) begin
				if (rdy[k]) v_s[k] <= (k == 0) ? in_valid : v_s[k-1];
			end
		end
	end

	// Trial-subtract the shifted divisor in each stage
	always_comb begin
		for (int k = 0; k < QB; k++) begin
			if (k == 0) begin
				pra[k]  = num_a;
				prb[k]  = num_b;
				pda[k]  = den_a;
				pdb[k]  = den_b;
				pqa[k]  = '0;
				pqb[k]  = '0;
				pctl[k] = ctl_in;
			end else begin
				pra[k]  = rem_a_s[k-1];
				prb[k]  = rem_b_s[k-1];
				pda[k]  = den_a_s[k-1];
				pdb[k]  = den_b_s[k-1];
				pqa[k]  = q_a_s[k-1];
				pqb[k]  = q_b_s[k-1];
				pctl[k] = ctl_s[k-1];
			end
			sha[k]  = NW'(pda[k]) << (QB - 1 - k);
			shb[k]  = NW'(pdb[k]) << (QB - 1 - k);
			ge_a[k] = (pra[k] >= sha[k]);
			ge_b[k] = (prb[k] >= shb[k]);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < QB; k++) begin
			if (rdy[k]) begin
				rem_a_s[k] <= ge_a[k] ? pra[k] - sha[k] : pra[k];
				rem_b_s[k] <= ge_b[k] ? prb[k] - shb[k] : prb[k];
				q_a_s[k]   <= {pqa[k][QB-2:0], ge_a[k]};
				q_b_s[k]   <= {pqb[k][QB-2:0], ge_b[k]};
				den_a_s[k] <= pda[k];
				den_b_s[k] <= pdb[k];
				ctl_s[k]   <= pctl[k];
			end
		end
	end

	assign out_valid = v_s[QB-1];
	assign quo_a     = q_a_s[QB-1];
	assign quo_b     = q_b_s[QB-1];
	assign den_a_out = den_a_s[QB-1];
	assign ctl_out   = ctl_s[QB-1];

endmodule

>>> rtl/rhc_back.sv
module rhc_back #(
	parameter int CB = rhc_pkg::COMPONENT_BITS,
	parameter int HF = rhc_pkg::HUE_FRACTION_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [((CB > rhc_pkg::SECTOR_BITS+HF) ? CB : rhc_pkg::SECTOR_BITS+HF)-1:0] quo_sat,
	input  logic [((CB > rhc_pkg::SECTOR_BITS+HF) ? CB : rhc_pkg::SECTOR_BITS+HF)-1:0] quo_hue,
	input  logic [CB-1:0]             mx,
	input  rhc_pkg::hue_ctl_t         ctl,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [rhc_pkg::HUE_W-1:0] hue,
	output logic [rhc_pkg::SAT_W-1:0] saturation,
	output logic [rhc_pkg::VAL_W-1:0] brightness,
	output logic                      hue_undefined
);

	localparam int QH   = rhc_pkg::SECTOR_BITS + HF;
	localparam int HW   = QH + 4;
	localparam int Sect = rhc_pkg::DEG_SECTOR * (2 ** HF);
	localparam int Full = rhc_pkg::DEG_FULL * (2 ** HF);
	localparam logic signed [HW-1:0] OffGreen = HW'(2 * Sect);
	localparam logic signed [HW-1:0] OffBlue  = HW'(4 * Sect);
	localparam logic signed [HW-1:0] FullS    = HW'(Full);

	logic v_s1, v_s2;
	logic rdy_s1, rdy_s2;

	logic signed [HW-1:0] qh_c, off_c, sum_c;

	logic signed [HW-1:0]        sum_s1;
	logic [rhc_pkg::SAT_W-1:0]   sat_s1;
	logic [rhc_pkg::VAL_W-1:0]   val_s1;
	logic                        undef_s1;

	logic [rhc_pkg::HUE_W-1:0]   hue_s2;
	logic [rhc_pkg::SAT_W-1:0]   sat_s2;
	logic [rhc_pkg::VAL_W-1:0]   val_s2;
	logic                        undef_s2;

	assign rdy_s2   = !v_s2 || out_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	// Add the sector offset to the signed quotient; force zero for gray and black
	always_comb begin
		qh_c = $signed(HW'(quo_hue[QH-1:0]));
		unique case (ctl.sector)
			rhc_pkg::SEC_RED:   off_c = '0;
			rhc_pkg::SEC_GREEN: off_c = OffGreen;
			rhc_pkg::SEC_BLUE:  off_c = OffBlue;
			default:            off_c = '0;
		endcase
		if (ctl.undef || ctl.gray) begin
			sum_c = '0;
		end else begin
			sum_c = off_c + (ctl.neg ? -qh_c : qh_c);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			sum_s1   <= sum_c;
			sat_s1   <= ctl.undef ? '0 : rhc_pkg::SAT_W'(quo_sat);
			val_s1   <= rhc_pkg::VAL_W'(mx);
			undef_s1 <= ctl.undef;
		end
	end

	// Wrap a negative hue by a full turn and hold the result
	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			hue_s2   <= rhc_pkg::HUE_W'((sum_s1 < 0) ? sum_s1 + FullS : sum_s1);
			sat_s2   <= sat_s1;
			val_s2   <= val_s1;
			undef_s2 <= undef_s1;
		end
	end

	assign out_valid     = v_s2;
	assign hue           = hue_s2;
	assign saturation    = sat_s2;
	assign brightness    = val_s2;
	assign hue_undefined = undef_s2;

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

	typedef struct packed {
		logic [rhc_pkg::HUE_W-1:0] hue;
		logic [rhc_pkg::SAT_W-1:0] sat;
		logic [rhc_pkg::VAL_W-1:0] val;
		logic                      undef;
	} hsv_t;

	// Expected HSV values for every accepted pixel, checked in arrival order
	class hsv_scoreboard;
		hsv_t hsv_due[$];
		int   mismatches;

		function hsv_t convert_pixel(logic [rhc_pkg::IN_W-1:0] r, logic [rhc_pkg::IN_W-1:0] g,
			logic [rhc_pkg::IN_W-1:0] b);
			int               mx, mn, delta, diff, off, h, sector_size, full_scale;
			rhc_pkg::sector_t sec;
			hsv_t             res;
			sector_size = rhc_pkg::DEG_SECTOR << rhc_pkg::HUE_FRACTION_BITS;
			full_scale  = (1 << rhc_pkg::COMPONENT_BITS) - 1;
			mx = r;
			mn = r;
			if (g > mx) mx = g;
			if (b > mx) mx = b;
			if (g < mn) mn = g;
			if (b < mn) mn = b;
			delta = mx - mn;
			res = '0;
			res.val = rhc_pkg::VAL_W'(mx);
			if (mx == 0) begin
				res.undef = 1'b1;
			end else begin
				res.sat = rhc_pkg::SAT_W'((delta * full_scale) / mx);
				if (delta != 0) begin
					// Red wins ties over green, green over blue
					if (r == mx) sec = rhc_pkg::SEC_RED;
					else if (g == mx) sec = rhc_pkg::SEC_GREEN;
					else sec = rhc_pkg::SEC_BLUE;
					case (sec)
					rhc_pkg::SEC_RED: begin
						off  = 0;
						diff = int'(g) - int'(b);
					end
					rhc_pkg::SEC_GREEN: begin
						off  = 2 * sector_size;
						diff = int'(b) - int'(r);
					end
					default: begin
						off  = 4 * sector_size;
						diff = int'(r) - int'(g);
					end
					endcase
					// Integer division truncates toward zero
					h = off + (sector_size * diff) / delta;
					if (h < 0) h += rhc_pkg::DEG_FULL << rhc_pkg::HUE_FRACTION_BITS;
					res.hue = rhc_pkg::HUE_W'(h);
				end
			end
			return res;
		endfunction

		function void note_pixel(logic [rhc_pkg::IN_W-1:0] r, logic [rhc_pkg::IN_W-1:0] g,
			logic [rhc_pkg::IN_W-1:0] b);
			hsv_due.push_back(convert_pixel(r, g, b));
		endfunction

		function void check_result(hsv_t got);
			hsv_t want;
			if (hsv_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: hue %0d sat %0d val %0d undef %0b",
						got.hue, got.sat, got.val, got.undef);
				return;
			end
			want = hsv_due.pop_front();
			if (got.hue !== want.hue || got.sat !== want.sat || got.val !== want.val ||
				got.undef !== want.undef) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch: expected hue %0d sat %0d val %0d undef %0b,",
						" got hue %0d sat %0d val %0d undef %0b"},
						want.hue, want.sat, want.val, want.undef,
						got.hue, got.sat, got.val, got.undef);
			end
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic [rhc_pkg::IN_W-1:0]  red, green, blue;
	logic                      out_valid;
	logic                      out_ready;
	logic [rhc_pkg::HUE_W-1:0] hue;
	logic [rhc_pkg::SAT_W-1:0] saturation;
	logic [rhc_pkg::VAL_W-1:0] brightness;
	logic                      hue_undefined;

	hsv_scoreboard board;
	bit            send_steady;
	bit            recv_steady;
	bit            hold_request;

	rgb_to_hsv_converter uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hue          (hue),
		.saturation   (saturation),
		.brightness   (brightness),
		.hue_undefined(hue_undefined)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Offer one pixel after a random gap and hold it until accepted
	task automatic send_pixel(logic [rhc_pkg::IN_W-1:0] r, logic [rhc_pkg::IN_W-1:0] g,
		logic [rhc_pkg::IN_W-1:0] b);
		int gap;
		if ($urandom_range(0, 63) == 0) send_steady = !send_steady;
		gap = send_steady ? 0 : $urandom_range(0, 3);
		repeat (gap) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		red      <= r;
		green    <= g;
		blue     <= b;
		do @(posedge clk); while (!in_ready);
		board.note_pixel(r, g, b);
	endtask

	// Pick a component from the edges of its range or anywhere
	function automatic logic [rhc_pkg::IN_W-1:0] edge_component();
		case ($urandom_range(0, 3))
		0: return '0;
		1: return '1;
		2: return rhc_pkg::IN_W'($urandom_range(0, 2));
		default: return rhc_pkg::IN_W'($urandom_range(0, 255));
		endcase
	endfunction

	// Check every item that leaves the block
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result('{hue, saturation, brightness, hue_undefined});
	end

	// Receiver: random stalls per item, plus long hold-offs on request
	initial begin
		int gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready <= 1'b0;
				repeat (60) @(posedge clk);
			end
			if ($urandom_range(0, 63) == 0) recv_steady = !recv_steady;
			gap = recv_steady ? 0 : $urandom_range(0, 3);
			repeat (gap) begin
				out_ready <= 1'b0;
				@(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		#200000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		int                       i;
		int                       mode;
		logic [rhc_pkg::IN_W-1:0] r, g, b, base;
		board        = new();
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		red          = '0;
		green        = '0;
		blue         = '0;
		hold_request = 1'b0;
		send_steady  = 1'b0;
		recv_steady  = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Black, gray and white pixels
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd1, 8'd1, 8'd1);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd255, 8'd255, 8'd255);
		// Primaries and smallest nonzero values
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd1, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd1, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd1);
		// Ties for the maximum
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd255);
		send_pixel(8'd7, 8'd7, 8'd3);
		// Negative hue that wraps, and sector boundaries
		send_pixel(8'd255, 8'd0, 8'd1);
		send_pixel(8'd255, 8'd1, 8'd0);
		send_pixel(8'd254, 8'd255, 8'd0);
		send_pixel(8'd1, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd1);
		send_pixel(8'd1, 8'd0, 8'd255);
		send_pixel(8'd0, 8'd1, 8'd255);
		send_pixel(8'd255, 8'd254, 8'd253);
		send_pixel(8'd200, 8'd100, 8'd50);

		// Random pixels: mostly uniform, some near-gray, some on the edges
		for (i = 0; i < 1300; i++) begin
			if (i == 200 || i == 900) hold_request = 1'b1;
			mode = $urandom_range(0, 19);
			if (mode < 14) begin
				r = rhc_pkg::IN_W'($urandom_range(0, 255));
				g = rhc_pkg::IN_W'($urandom_range(0, 255));
				b = rhc_pkg::IN_W'($urandom_range(0, 255));
			end else if (mode < 17) begin
				base = rhc_pkg::IN_W'($urandom_range(0, 255));
				r = base;
				g = base ^ rhc_pkg::IN_W'($urandom_range(0, 1));
				b = base ^ rhc_pkg::IN_W'($urandom_range(0, 3));
			end else begin
				r = edge_component();
				g = edge_component();
				b = edge_component();
			end
			send_pixel(r, g, b);
		end
		in_valid <= 1'b0;

		// Drain, then allow any stray item to show up
		while (board.hsv_due.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (board.mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
